### hdl/lpb_pkg.sv
// ----------------------------------------------------------------------------
// lpb_pkg
// Shared types, codes and the microcode table of the prime search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lpb_pkg;

  // Width of the limit and prime fields on the stream ports.
  localparam int DATA_W = 16;

  // Step counter width and step addresses of the microprogram.
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_CHECK = 4'd1;
  localparam step_t STEP_TEST  = 4'd2;
  localparam step_t STEP_DIV   = 4'd3;
  localparam step_t STEP_REM   = 4'd4;
  localparam step_t STEP_NXTD  = 4'd5;
  localparam step_t STEP_NXTC  = 4'd6;
  localparam step_t STEP_FOUND = 4'd7;
  localparam step_t STEP_NONE  = 4'd8;

  // Datapath operations.
  typedef logic [3:0] op_t;

  localparam op_t OP_NOP       = 4'd0;
  localparam op_t OP_LOAD      = 4'd1;
  localparam op_t OP_SET_CAND  = 4'd2;
  localparam op_t OP_CLR_REM   = 4'd3;
  localparam op_t OP_DIV_STEP  = 4'd4;
  localparam op_t OP_NEXT_D    = 4'd5;
  localparam op_t OP_NEXT_CAND = 4'd6;
  localparam op_t OP_PUT_PRIME = 4'd7;
  localparam op_t OP_PUT_NONE  = 4'd8;

  // Jump conditions.
  typedef logic [2:0] cond_t;

  localparam cond_t COND_ALWAYS   = 3'd0;
  localparam cond_t COND_IN_VALID = 3'd1;
  localparam cond_t COND_LIM_LE2  = 3'd2;
  localparam cond_t COND_SQ_GT    = 3'd3;
  localparam cond_t COND_CNT_ZERO = 3'd4;
  localparam cond_t COND_REM_ZERO = 3'd5;
  localparam cond_t COND_OUT_FREE = 3'd6;

  // One control word. When the condition holds the sequencer jumps to the
  // target, otherwise it holds or falls through. A gated operation only
  // executes in the cycle in which its condition holds.
  typedef struct packed {
    logic  ready;
    op_t   op;
    logic  gate;
    cond_t cond;
    logic  hold;
    step_t target;
  } uword_t;

  // Operation handed from the sequencer to the datapath.
  typedef struct packed {
    op_t  op;
    logic en;
  } ctrl_t;

  // Flags returned from the datapath to the sequencer.
  typedef struct packed {
    logic lim_le2;
    logic sq_gt;
    logic cnt_zero;
    logic rem_zero;
    logic out_free;
  } stat_t;

  function automatic uword_t ucode(input step_t addr);
    uword_t w;
    w = '{1'b0, OP_NOP, 1'b0, COND_ALWAYS, 1'b0, STEP_IDLE};
    case (addr)
      STEP_IDLE:  w = '{1'b1, OP_LOAD,      1'b1, COND_IN_VALID, 1'b1, STEP_CHECK};
      STEP_CHECK: w = '{1'b0, OP_SET_CAND,  1'b0, COND_LIM_LE2,  1'b0, STEP_NONE};
      STEP_TEST:  w = '{1'b0, OP_CLR_REM,   1'b0, COND_SQ_GT,    1'b0, STEP_FOUND};
      STEP_DIV:   w = '{1'b0, OP_DIV_STEP,  1'b0, COND_CNT_ZERO, 1'b1, STEP_REM};
      STEP_REM:   w = '{1'b0, OP_NOP,       1'b0, COND_REM_ZERO, 1'b0, STEP_NXTC};
      STEP_NXTD:  w = '{1'b0, OP_NEXT_D,    1'b0, COND_ALWAYS,   1'b0, STEP_TEST};
      STEP_NXTC:  w = '{1'b0, OP_NEXT_CAND, 1'b0, COND_ALWAYS,   1'b0, STEP_TEST};
      STEP_FOUND: w = '{1'b0, OP_PUT_PRIME, 1'b1, COND_OUT_FREE, 1'b1, STEP_IDLE};
      STEP_NONE:  w = '{1'b0, OP_PUT_NONE,  1'b1, COND_OUT_FREE, 1'b1, STEP_IDLE};
      default:    w = '{1'b0, OP_NOP,       1'b0, COND_ALWAYS,   1'b0, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hdl/lpb_seq.sv
// ----------------------------------------------------------------------------
// lpb_seq
// Step counter, microcode lookup and conditional jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module lpb_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire lpb_pkg::stat_t stat,
  output lpb_pkg::ctrl_t      ctrl
);

  lpb_pkg::step_t  upc_r;
  lpb_pkg::step_t  upc_nxt;
  lpb_pkg::uword_t word;
  logic            cond_true;

  assign word = lpb_pkg::ucode(upc_r);

  always_comb begin
    case (word.cond)
      lpb_pkg::COND_ALWAYS:   cond_true = 1'b1;
      lpb_pkg::COND_IN_VALID: cond_true = in_tvalid;
      lpb_pkg::COND_LIM_LE2:  cond_true = stat.lim_le2;
      lpb_pkg::COND_SQ_GT:    cond_true = stat.sq_gt;
      lpb_pkg::COND_CNT_ZERO: cond_true = stat.cnt_zero;
      lpb_pkg::COND_REM_ZERO: cond_true = stat.rem_zero;
      lpb_pkg::COND_OUT_FREE: cond_true = stat.out_free;
      default:                cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      upc_nxt = word.target;
    end else if (word.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + lpb_pkg::step_t'(1);
    end
  end

  assign in_tready = word.ready;
  assign ctrl.op   = word.op;
  assign ctrl.en   = !word.gate || cond_true;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= lpb_pkg::STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // An accepted transaction always starts the limit check next.
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (upc_r == lpb_pkg::STEP_CHECK))
    else $error("accepted limit did not move to the check step");

  // The step counter never leaves the programme.
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= lpb_pkg::STEP_NONE)
    else $error("step counter outside the microprogram");

  // Input is only taken in the idle step.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (upc_r == lpb_pkg::STEP_IDLE))
    else $error("ready raised outside the idle step");

endmodule

`default_nettype wire

### hdl/lpb_dpath.sv
// ----------------------------------------------------------------------------
// lpb_dpath
// Candidate, divisor and remainder registers, bit-serial remainder unit and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpb_dpath #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [lpb_pkg::DATA_W-1:0]  in_tdata,
  input  wire lpb_pkg::ctrl_t              ctrl,
  output lpb_pkg::stat_t                   stat,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [lpb_pkg::DATA_W-1:0]       out_tdata,
  output logic                             out_tuser
);

  // Only the low bits of the limit take part in the search.
  localparam int VW = (VALUE_BITS < lpb_pkg::DATA_W) ? VALUE_BITS : lpb_pkg::DATA_W;
  localparam int CW = $clog2(VW);

  logic [VW-1:0] lim_r,   lim_nxt;
  logic [VW-1:0] cand_r,  cand_nxt;
  logic [VW-1:0] d_r,     d_nxt;
  logic [VW:0]   sq_r,    sq_nxt;
  logic [VW:0]   rem_r,   rem_nxt;
  logic [CW-1:0] cnt_r,   cnt_nxt;
  logic [VW-1:0] prime_r, prime_nxt;
  logic          found_r, found_nxt;
  logic          valid_r, valid_nxt;
  logic [VW:0]   rem_sh;
  logic          out_free;

  // One restoring remainder step: bring in the next candidate bit.
  assign rem_sh   = {rem_r[VW-1:0], cand_r[cnt_r]};
  assign out_free = !valid_r || out_tready;

  always_comb begin
    lim_nxt   = lim_r;
    cand_nxt  = cand_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    prime_nxt = prime_r;
    found_nxt = found_r;
    valid_nxt = valid_r && !out_tready;
    if (ctrl.en) begin
      case (ctrl.op)
        lpb_pkg::OP_LOAD: begin
          lim_nxt = in_tdata[VW-1:0];
        end
        lpb_pkg::OP_SET_CAND: begin
          cand_nxt = lim_r - VW'(1);
          d_nxt    = VW'(2);
          sq_nxt   = (VW+1)'(4);
        end
        lpb_pkg::OP_CLR_REM: begin
          rem_nxt = '0;
          cnt_nxt = CW'(VW - 1);
        end
        lpb_pkg::OP_DIV_STEP: begin
          rem_nxt = (rem_sh >= {1'b0, d_r}) ? rem_sh - {1'b0, d_r} : rem_sh;
          cnt_nxt = cnt_r - CW'(1);
        end
        lpb_pkg::OP_NEXT_D: begin
          // (d+1)^2 = d^2 + 2d + 1
          d_nxt  = d_r + VW'(1);
          sq_nxt = sq_r + {d_r, 1'b1};
        end
        lpb_pkg::OP_NEXT_CAND: begin
          cand_nxt = cand_r - VW'(1);
          d_nxt    = VW'(2);
          sq_nxt   = (VW+1)'(4);
        end
        lpb_pkg::OP_PUT_PRIME: begin
          prime_nxt = cand_r;
          found_nxt = 1'b1;
          valid_nxt = 1'b1;
        end
        lpb_pkg::OP_PUT_NONE: begin
          prime_nxt = '0;
          found_nxt = 1'b0;
          valid_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      d_r     <= VW'(2);
      sq_r    <= (VW+1)'(4);
    end else begin
      valid_r <= valid_nxt;
      d_r     <= d_nxt;
      sq_r    <= sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r   <= lim_nxt;
    cand_r  <= cand_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    prime_r <= prime_nxt;
    found_r <= found_nxt;
  end

  assign stat.lim_le2  = lim_r <= VW'(2);
  assign stat.sq_gt    = sq_r > {1'b0, cand_r};
  assign stat.cnt_zero = cnt_r == '0;
  assign stat.rem_zero = rem_r == '0;
  assign stat.out_free = out_free;

  assign out_tvalid = valid_r;
  assign out_tdata  = lpb_pkg::DATA_W'(prime_r);
  assign out_tuser  = found_r;

  // The running square always matches the divisor.
  a_square: assert property (@(posedge clk) disable iff (!rst_n)
    (2*VW)'(sq_r) == (2*VW)'(d_r) * (2*VW)'(d_r))
    else $error("running square out of step with divisor");

  // A reported prime lies in [2, limit).
  a_prime_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.en && ctrl.op == lpb_pkg::OP_PUT_PRIME)
      |=> (out_tuser && prime_r >= VW'(2) && prime_r < lim_r))
    else $error("reported prime outside the search range");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.en && (ctrl.op == lpb_pkg::OP_PUT_PRIME || ctrl.op == lpb_pkg::OP_PUT_NONE))
      |-> out_free)
    else $error("result written while the previous one waits");

endmodule

`default_nettype wire

### hdl/largest_prime_below.sv
// ----------------------------------------------------------------------------
// largest_prime_below
// Finds the largest prime strictly below a limit by trial division, run by a
// small microprogram over a datapath with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  tdata (low bit up)       tuser
//   in_       slave      limit[15:0]              -
//   out_      master     prime[15:0]              found
//
// Candidates count down from limit-1. Each candidate is tried against the
// divisors d = 2, 3, ... while d*d does not exceed it, and each trial costs
// one remainder of VALUE_BITS single-bit steps (capped at 16). The search
// time grows with the number of trial divisors over all candidates, so a
// search that passes composites whose smallest factor is large takes longer.
// Reset clears the step counter, the result valid flag and the divisor with
// its running square. A new limit is taken while a finished result still
// waits on a stalled output; the search then stops before writing its own
// result until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module largest_prime_below #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [lpb_pkg::DATA_W-1:0] in_tdata,   // limit
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [lpb_pkg::DATA_W-1:0]      out_tdata,  // prime
  output logic                            out_tuser   // found
);

  // Operation selected by the current control word, and the flags the
  // datapath hands back for the jump conditions.
  lpb_pkg::ctrl_t ctrl;
  lpb_pkg::stat_t stat;

  // The sequencer steps through the microprogram: it waits for a limit,
  // rejects limits of two or less, then alternates between the square test
  // and the remainder loop until a candidate survives every divisor.
  lpb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // The datapath holds the candidate, the divisor and its running square,
  // the remainder under construction and the output register.
  lpb_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### dv/tb_largest_prime_below.sv
// ----------------------------------------------------------------------------
// tb_largest_prime_below
// Self-checking stream testbench for the trial-division prime search.
// ----------------------------------------------------------------------------
// Limits are sent on the input stream. Each accepted limit is turned into the
// expected prime and found flag by an independent search in the testbench.
// Results leaving the block are compared in order with those expectations.
// A directed set covers the smallest limits, the top of the range and the
// wide bit patterns. A random set follows, weighted towards small and medium
// limits so that the run stays short. Both the sender and the receiver pause
// at random, with some stretches that have no pauses at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_largest_prime_below;

  localparam int DATA_W       = lpb_pkg::DATA_W;
  localparam int VALUE_BITS   = 16;
  localparam int RANDOM_ITEMS = 270;
  localparam int SEGMENT      = 20;
  // No transaction on either side for this many cycles ends the run. The
  // limit must outlast the slowest search and the longest receiver stall.
  localparam int STALL_LIMIT  = 200000;
  localparam int SETTLE       = 64;

  // --------------------------------------------------------------------------
  // Scoreboard: works out the expected prime for each accepted limit and
  // compares every result transaction with the oldest expectation.
  // --------------------------------------------------------------------------
  class prime_scoreboard;
    typedef struct packed {
      logic [DATA_W-1:0] prime;
      logic              found;
    } prime_result_t;

    prime_result_t expected_primes[$];
    int            mismatches;

    function bit has_no_divisor(int cand);
      if (cand < 2) return 1'b0;
      for (int d = 2; d * d <= cand; d++) begin
        if (cand % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Counts down from limit-1 and stops at 2, so 1 never counts as a prime.
    function prime_result_t search_below(logic [DATA_W-1:0] limit);
      prime_result_t res;
      int            lim;
      res = '0;
      lim = int'(limit) & ((1 << VALUE_BITS) - 1);
      for (int cand = lim - 1; cand >= 2; cand--) begin
        if (has_no_divisor(cand)) begin
          res.prime = cand[DATA_W-1:0];
          res.found = 1'b1;
          return res;
        end
      end
      return res;
    endfunction

    function void fail(string what);
      mismatches++;
      if (mismatches <= 10) $display("ERROR %t: %s", $realtime, what);
    endfunction

    function void note_limit(logic [DATA_W-1:0] limit);
      expected_primes.push_back(search_below(limit));
    endfunction

    function void check_result(logic [DATA_W-1:0] prime, logic found);
      prime_result_t exp;
      if (expected_primes.size() == 0) begin
        fail($sformatf("unexpected result prime=%0d found=%0b", prime, found));
        return;
      end
      exp = expected_primes.pop_front();
      if (prime !== exp.prime)
        fail($sformatf("prime: expected %0d, got %0d", exp.prime, prime));
      if (found !== exp.found)
        fail($sformatf("found: expected %0b, got %0b", exp.found, found));
    endfunction

    function int pending();
      return expected_primes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's inputs. Every input has a known value from
  // time zero.
  // --------------------------------------------------------------------------
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic [DATA_W-1:0] in_tdata   = '0;   // limit
  logic              out_tready = 1'b0;
  logic              in_tready;
  logic              out_tvalid;
  logic [DATA_W-1:0] out_tdata;         // prime
  logic              out_tuser;         // found

  // When set, the receiver takes every result without stalling.
  bit                sink_steady = 1'b0;
  int                idle_cycles = 0;
  prime_scoreboard   sb;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  largest_prime_below #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Pause lengths: mostly none or short, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 24);
    return $urandom_range(60, 400);
  endfunction

  // Limits are mostly small, since the search time grows quickly with the
  // limit; an eighth lie from 4096 up and one in twelve spans the full 16-bit range.
  function automatic logic [DATA_W-1:0] pick_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return DATA_W'($urandom_range(0, 8));
    if (r < 55) return DATA_W'($urandom_range(9, 255));
    if (r < 80) return DATA_W'($urandom_range(256, 4095));
    if (r < 92) return DATA_W'($urandom_range(4096, 65535));
    return DATA_W'($urandom);
  endfunction

  // Called at a rising edge. Optionally idles first, then holds the limit
  // until the block takes it. Returns at the edge of the transaction, so the
  // next call may raise valid again in the same time step without a dip.
  task automatic send_limit(input logic [DATA_W-1:0] limit, input int unsigned gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= DATA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= limit;
    do @(posedge clk); while (!in_tready);
    sb.note_limit(limit);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: ready in runs of random length, with stalls between them. The
  // long stalls leave a finished result waiting while the next limit is
  // already being searched.
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!sink_steady) begin
        stall = ($urandom_range(0, 49) == 0) ? $urandom_range(500, 3000) : idle_length();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Watchdog: counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [DATA_W-1:0] directed_limits[$];
    bit                steady;
    sb = new();
    directed_limits = '{
      16'd0, 16'd1, 16'd2,          // nothing below, no prime reported
      16'd3, 16'd4, 16'd5, 16'd6,   // smallest primes, 2, 3 and 5
      16'd9, 16'd17, 16'd18, 16'd100,
      16'd256, 16'd1024,
      16'hFFFF, 16'hFFFE,           // top of the range
      16'd65521, 16'd65522,         // just at and just above the largest prime
      16'h8000, 16'hAAAA, 16'h5555, 16'h7FFF
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, back to back, with the receiver never stalling.
    sink_steady = 1'b1;
    foreach (directed_limits[i]) send_limit(directed_limits[i], 0);
    drain_results();
    sink_steady = 1'b0;

    // Random part in segments; some segments run with no pauses on either
    // side, and now and then the sender waits for the block to empty.
    for (int seg = 0; seg < RANDOM_ITEMS / SEGMENT; seg++) begin
      steady = ($urandom_range(0, 3) == 0);
      sink_steady = steady;
      for (int i = 0; i < SEGMENT; i++) begin
        send_limit(pick_limit(), steady ? 0 : idle_length());
      end
      if ($urandom_range(0, 4) == 0) drain_results();
    end
    in_tvalid <= 1'b0;
    sink_steady = 1'b0;

    // Wait for the last results, then give the block a little longer to show
    // any extra transaction.
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
